### rtl/sifs_pkg.sv
// Package for the spectral index flux scaler.
// Fixed-point widths, constants, register indexes and default parameters.
// No dependencies.
package sifs_pkg;

  localparam int QB            = 30;   // internal fraction bits
  localparam int FREQ_W        = 32;
  localparam int FLUX_W        = 32;
  localparam int COEF_W        = 32;
  localparam int CNT_W         = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int NUM_COEF_REGS = 5;
  localparam int EXP_TERMS     = 12;

  localparam int LOG_W = 35;           // unsigned log2, 5 integer + QB fraction bits
  localparam int D_W   = 37;           // signed log difference / multiplier b operand
  localparam int E_W   = 56;           // signed clipped Q.30 value, +-2^54
  localparam int N_W   = E_W - QB;     // integer part of a clipped value

  localparam int LOG_LAT = QB + 1;
  localparam int MUL_LAT = 2;
  localparam int EXP_LAT = 2 * EXP_TERMS + 1;

  localparam logic [QB-1:0]  LN2_Q  = 30'h2C5C85FE;
  localparam logic [31:0]    ONE_Q  = 32'h4000_0000;
  localparam logic [E_W-2:0] VLIM   = (E_W-1)'(1) << 54;

  localparam int DEF_MAX_COEFFS     = 5;
  localparam int DEF_COEF_FRAC_BITS = 24;

  localparam logic [FREQ_W-1:0] RST_REF_FREQ   = 32'd150000000;
  localparam logic [FLUX_W-1:0] RST_STOKES_REF = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_FREQ   = 3'd0,
    REG_STOKES_REF = 3'd1,
    REG_COEF_COUNT = 3'd2,
    REG_COEF0      = 3'd3,
    REG_COEF1      = 3'd4,
    REG_COEF2      = 3'd5,
    REG_COEF3      = 3'd6,
    REG_COEF4      = 3'd7
  } reg_idx_t;

endpackage

### rtl/sifs_if.sv
// Channel interfaces of the spectral index flux scaler.
// Depends on sifs_pkg for field widths.
interface sifs_freq_if import sifs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] chan_freq;
  modport source (output valid, output chan_freq, input ready);
  modport sink   (input valid, input chan_freq, output ready);
endinterface

interface sifs_flux_if import sifs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [FLUX_W-1:0] flux;
  logic                     saturated;
  modport source (output valid, output flux, output saturated, input ready);
  modport sink   (input valid, input flux, input saturated, output ready);
endinterface

interface sifs_cfg_if import sifs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sifs_log2.sv
// Pipelined base-2 logarithm of a 32-bit value, QB fraction bits.
// One squaring of the mantissa per stage. Depends on sifs_pkg.
module sifs_log2 import sifs_pkg::*; (
  input  logic              clk,
  input  logic              ce,
  input  logic [FREQ_W-1:0] x,
  output logic [LOG_W-1:0]  res
);

  logic [31:0]   mq [0:QB];
  logic [4:0]    pq [0:QB];
  logic [QB-1:0] fq [0:QB];

  logic [31:0] xx;
  logic [4:0]  pos;

  always_comb begin
    xx  = (x == '0) ? 32'd1 : x;
    pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (xx[i]) pos = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      mq[0] <= xx << (5'd31 - pos);
      pq[0] <= pos;
      fq[0] <= '0;
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = mq[i] * mq[i];
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (ce) begin
        mq[i+1] <= t[32] ? t[32:1] : t[31:0];
        fq[i+1] <= {fq[i][QB-2:0], t[32]};
        pq[i+1] <= pq[i];
      end
    end
  end

  assign res = {pq[QB], fq[QB]};

endmodule

### rtl/sifs_mulq.sv
// Two-stage signed Q.30 multiplier: truncates toward zero, clips to +-2^54.
// Partial products in the first stage, sum and clip in the second. Depends on sifs_pkg.
module sifs_mulq import sifs_pkg::*; (
  input  logic                  clk,
  input  logic                  ce,
  input  logic signed [E_W-1:0] a,
  input  logic signed [D_W-1:0] b,
  output logic signed [E_W-1:0] p,
  output logic                  ovf
);

  localparam int HI_W = E_W - 32;
  localparam int FW   = E_W + D_W;

  logic [E_W-1:0]     am;
  logic [D_W-1:0]     bm;
  logic [32+D_W-1:0]  plo;
  logic [HI_W+D_W-1:0] phi;
  logic               neg;
  logic [FW-1:0]      full;
  logic [FW-QB-1:0]   r;
  logic               big;
  logic [E_W-2:0]     rmag;

  assign am = a[E_W-1] ? (~a + 1'b1) : a;
  assign bm = b[D_W-1] ? (~b + 1'b1) : b;

  always_ff @(posedge clk) begin
    if (ce) begin
      plo <= am[31:0] * bm;
      phi <= am[E_W-1:32] * bm;
      neg <= a[E_W-1] ^ b[D_W-1];
    end
  end

  always_comb begin
    full = FW'(plo) + (FW'(phi) << 32);
    r    = full[FW-1:QB];
    big  = r > (FW-QB)'(VLIM);
    rmag = big ? VLIM : r[E_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p   <= neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
      ovf <= big;
    end
  end

endmodule

### rtl/sifs_exp2.sv
// Pipelined 2^f for a QB-bit fraction: 12-term Taylor series in Horner form.
// Two stages per term (multiply, then divide by a constant). Depends on sifs_pkg.
module sifs_exp2 import sifs_pkg::*; (
  input  logic          clk,
  input  logic          ce,
  input  logic [QB-1:0] f,
  output logic [31:0]   g
);

  logic [2*QB-1:0] fy;
  logic [QB-1:0]   yq [0:EXP_TERMS];
  logic [QB-1:0]   ya [0:EXP_TERMS-1];
  logic [31:0]     gq [0:EXP_TERMS];
  logic [31:0]     tq [0:EXP_TERMS-1];

  assign fy    = f * LN2_Q;
  assign gq[0] = ONE_Q;

  always_ff @(posedge clk) begin
    if (ce) yq[0] <= fy[2*QB-1:QB];
  end

  for (genvar s = 0; s < EXP_TERMS; s++) begin : g_term
    localparam int K = EXP_TERMS - s;
    localparam logic [36:0] RECIP = 37'((64'd1 << 36) / K);
    localparam logic [31:0] KC = 32'(K);

    logic [QB+31:0] gy;
    logic [68:0]    rp;
    logic [31:0]    q0;
    logic [31:0]    rem;
    logic [31:0]    q;

    assign gy = gq[s] * yq[s];

    always_ff @(posedge clk) begin
      if (ce) begin
        tq[s] <= gy[QB+31:QB];
        ya[s] <= yq[s];
      end
    end

    // reciprocal estimate is low by at most one
    always_comb begin
      rp  = tq[s] * RECIP;
      q0  = rp[67:36];
      rem = tq[s] - q0 * KC;
      q   = (rem >= KC) ? q0 + 32'd1 : q0;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        gq[s+1] <= ONE_Q + q;
        yq[s+1] <= ya[s];
      end
    end
  end

  assign g = gq[EXP_TERMS];

endmodule

### rtl/spectral_index_flux_scaler_unit.sv
// Spectral index flux scaler: flux = I0 * (v/v0)^(c0 + c1*L + ...), L = ln(v/v0).
// Top level: registers, Horner pipeline, final scaling, output queue.
// Depends on sifs_pkg, sifs_if, sifs_log2, sifs_mulq, sifs_exp2.
//
//   channel  dir  handshake     payload
//   freq     in   valid/ready   chan_freq[31:0]
//   result   out  valid/ready   flux[31:0] signed Q16.16, saturated
//   cfg      in   valid/ready   index[2:0], data[31:0]
//
// One item per cycle while the output queue is not full; 63 + 3*MAX_COEFFS pipeline
// stages, set by the 30 squaring stages of the logarithm, three stages per Horner term
// and two per exp term. Synchronous reset clears the valid bits and the queue pointers
// and count, and loads the configuration registers with their reset values. A two-entry
// output queue takes results while the sink stalls; the pipeline holds as a whole only
// when the queue is full. cfg is always ready.
module spectral_index_flux_scaler_unit import sifs_pkg::*; #(
  parameter int MAX_COEFFS     = DEF_MAX_COEFFS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst,
  sifs_freq_if.sink  freq,
  sifs_flux_if.source result,
  sifs_cfg_if.sink   cfg
);

  localparam int CNT_LIM = (MAX_COEFFS < NUM_COEF_REGS) ? MAX_COEFFS : NUM_COEF_REGS;
  localparam int CSH     = QB - COEF_FRAC_BITS;
  localparam int P_L     = LOG_LAT + 1 + MUL_LAT;
  localparam int P_E     = P_L + 3 * MAX_COEFFS;
  localparam int P_U     = P_E + MUL_LAT;
  localparam int LAT     = P_U + EXP_LAT + 2;

  // configuration registers
  logic        [FREQ_W-1:0] ref_freq;
  logic signed [FLUX_W-1:0] stokes_ref;
  logic        [CNT_W-1:0]  coef_count;
  logic        [COEF_W-1:0] coefs [0:NUM_COEF_REGS-1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_freq   <= RST_REF_FREQ;
      stokes_ref <= RST_STOKES_REF;
      coef_count <= '0;
      for (int i = 0; i < NUM_COEF_REGS; i++) coefs[i] <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_REF_FREQ:   ref_freq   <= cfg.data;
        REG_STOKES_REF: stokes_ref <= cfg.data;
        REG_COEF_COUNT: coef_count <= cfg.data[CNT_W-1:0];
        REG_COEF0:      coefs[0]   <= cfg.data;
        REG_COEF1:      coefs[1]   <= cfg.data;
        REG_COEF2:      coefs[2]   <= cfg.data;
        REG_COEF3:      coefs[3]   <= cfg.data;
        REG_COEF4:      coefs[4]   <= cfg.data;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cnt_eff;
  logic             pass;
  assign cnt_eff = (coef_count > CNT_W'(CNT_LIM)) ? CNT_W'(CNT_LIM) : coef_count;
  assign pass    = (cnt_eff == '0) || (cnt_eff == CNT_W'(1) && coefs[0] == '0);

  // pipeline control
  logic [1:0] fcnt;
  logic       ce;
  logic       vld [0:LAT];

  assign ce         = (fcnt != 2'd2);
  assign freq.ready = ce;
  assign vld[0]     = freq.valid & ce;

  for (genvar i = 1; i <= LAT; i++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) vld[i] <= 1'b0;
      else if (ce) vld[i] <= vld[i-1];
    end
  end

  // logarithms
  logic [LOG_W-1:0] lc, lr;
  sifs_log2 u_log_chan (.clk, .ce, .x(freq.chan_freq), .res(lc));
  sifs_log2 u_log_ref  (.clk, .ce, .x(ref_freq),       .res(lr));

  logic signed [D_W-1:0] d;
  always_ff @(posedge clk) begin
    if (ce) d <= $signed(D_W'(lc)) - $signed(D_W'(lr));
  end

  // L = D * ln2
  logic signed [E_W-1:0] l_full;
  logic                  l_ovf;
  logic signed [D_W-1:0] d_l [0:MUL_LAT];
  assign d_l[0] = d;
  for (genvar i = 0; i < MUL_LAT; i++) begin : g_dl
    always_ff @(posedge clk) if (ce) d_l[i+1] <= d_l[i];
  end

  sifs_mulq u_mul_l (
    .clk, .ce,
    .a  (E_W'(d)),
    .b  ($signed({{(D_W-QB){1'b0}}, LN2_Q})),
    .p  (l_full),
    .ovf(l_ovf)
  );

  // Horner terms, highest index first; unused terms keep the sum at zero
  logic signed [E_W-1:0] e_h [0:MAX_COEFFS];
  logic signed [D_W-1:0] l_h [0:MAX_COEFFS];
  logic signed [D_W-1:0] d_h [0:MAX_COEFFS];
  logic                  s_h [0:MAX_COEFFS];

  assign e_h[0] = '0;
  assign l_h[0] = l_full[D_W-1:0];
  assign d_h[0] = d_l[MUL_LAT];
  assign s_h[0] = l_ovf;

  for (genvar j = 0; j < MAX_COEFFS; j++) begin : g_horner
    localparam int CI = MAX_COEFFS - 1 - j;
    localparam int RI = (CI < NUM_COEF_REGS) ? CI : NUM_COEF_REGS - 1;

    logic signed [E_W-1:0] mp;
    logic                  mo;
    logic signed [D_W-1:0] la, lb, da, db;
    logic                  sa, sb;
    logic                  active;
    logic signed [E_W-1:0] cq;
    logic signed [E_W:0]   sum;

    sifs_mulq u_mul (.clk, .ce, .a(e_h[j]), .b(l_h[j]), .p(mp), .ovf(mo));

    always_ff @(posedge clk) begin
      if (ce) begin
        la <= l_h[j]; lb <= la;
        da <= d_h[j]; db <= da;
        sa <= s_h[j]; sb <= sa;
      end
    end

    assign active = 5'(CI) < 5'(cnt_eff);
    assign cq     = E_W'($signed(coefs[RI])) <<< CSH;
    assign sum    = (E_W+1)'(mp) + (E_W+1)'(cq);

    always_ff @(posedge clk) begin
      if (ce) begin
        l_h[j+1] <= lb;
        d_h[j+1] <= db;
        if (!active) begin
          e_h[j+1] <= '0;
          s_h[j+1] <= sb | mo;
        end else if (sum > $signed({2'b00, VLIM})) begin
          e_h[j+1] <= $signed({1'b0, VLIM});
          s_h[j+1] <= 1'b1;
        end else if (sum < -$signed({2'b00, VLIM})) begin
          e_h[j+1] <= -$signed({1'b0, VLIM});
          s_h[j+1] <= 1'b1;
        end else begin
          e_h[j+1] <= sum[E_W-1:0];
          s_h[j+1] <= sb | mo;
        end
      end
    end
  end

  // U = D * E
  logic signed [E_W-1:0] u;
  logic                  u_ovf;
  logic                  s_u [0:MUL_LAT];
  assign s_u[0] = s_h[MAX_COEFFS];
  for (genvar i = 0; i < MUL_LAT; i++) begin : g_su
    always_ff @(posedge clk) if (ce) s_u[i+1] <= s_u[i];
  end

  sifs_mulq u_mul_u (
    .clk, .ce, .a(e_h[MAX_COEFFS]), .b(d_h[MAX_COEFFS]), .p(u), .ovf(u_ovf)
  );

  // 2^f, with floor(U) and the flag riding alongside
  logic        [31:0]    g;
  logic signed [N_W-1:0] n_x [0:EXP_LAT];
  logic                  s_x [0:EXP_LAT];
  assign n_x[0] = u[E_W-1:QB];
  assign s_x[0] = s_u[MUL_LAT] | u_ovf;
  for (genvar i = 0; i < EXP_LAT; i++) begin : g_nx
    always_ff @(posedge clk) begin
      if (ce) begin
        n_x[i+1] <= n_x[i];
        s_x[i+1] <= s_x[i];
      end
    end
  end

  sifs_exp2 u_exp (.clk, .ce, .f(u[QB-1:0]), .g(g));

  // I0 * 2^f
  logic [FLUX_W-1:0]     i0m;
  logic [63:0]           m;
  logic signed [N_W-1:0] n_m;
  logic                  s_m;
  assign i0m = stokes_ref[FLUX_W-1] ? (~stokes_ref + 1'b1) : stokes_ref;

  always_ff @(posedge clk) begin
    if (ce) begin
      m   <= i0m * g;
      n_m <= n_x[EXP_LAT];
      s_m <= s_x[EXP_LAT];
    end
  end

  // scale by 2^n, round half away from zero, clip
  logic signed [N_W:0]      sh;
  logic [64:0]              rsum;
  logic [64:0]              mag;
  logic signed [FLUX_W-1:0] flux_c;
  logic                     sat_c;
  logic signed [FLUX_W-1:0] flux_r;
  logic                     sat_r;

  always_comb begin
    sh   = (N_W+1)'(QB) - (N_W+1)'(n_m);
    rsum = '0;
    if (m == '0 || sh >= (N_W+1)'(63)) begin
      mag = '0;
    end else if (sh >= (N_W+1)'(1)) begin
      rsum = {1'b0, m} + (65'd1 << (sh[5:0] - 6'd1));
      mag  = rsum >> sh[5:0];
    end else if (sh == '0) begin
      mag = {1'b0, m};
    end else if (sh == -(N_W+1)'(1)) begin
      mag = {m, 1'b0};
    end else begin
      mag = 65'd1 << 33;
    end
    sat_c = s_m;
    if (stokes_ref[FLUX_W-1]) begin
      if (mag > (65'd1 << 31)) begin
        flux_c = $signed(32'h8000_0000);
        sat_c  = 1'b1;
      end else begin
        flux_c = -$signed(mag[FLUX_W-1:0]);
      end
    end else begin
      if (mag > 65'h7FFF_FFFF) begin
        flux_c = $signed(32'h7FFF_FFFF);
        sat_c  = 1'b1;
      end else begin
        flux_c = $signed(mag[FLUX_W-1:0]);
      end
    end
    if (pass) begin
      flux_c = stokes_ref;
      sat_c  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      flux_r <= flux_c;
      sat_r  <= sat_c;
    end
  end

  // output queue
  logic signed [FLUX_W-1:0] q_flux [0:1];
  logic                     q_sat  [0:1];
  logic                     wr_ptr, rd_ptr;
  logic                     push, pop;

  assign push = ce & vld[LAT];
  assign pop  = result.valid & result.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_flux[wr_ptr] <= flux_r;
      q_sat[wr_ptr]  <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fcnt   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fcnt <= fcnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign result.valid     = (fcnt != '0);
  assign result.flux      = q_flux[rd_ptr];
  assign result.saturated = q_sat[rd_ptr];

`ifndef ASSERT_OFF
  ap_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  ap_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> fcnt == $past(fcnt) + {1'b0, $past(push)} - {1'b0, $past(pop)})
    else $error("output queue count lost track of push/pop");

  ap_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> (fcnt != 2'd2) && (wr_ptr == (rd_ptr ^ fcnt[0])))
    else $error("result pushed into a full queue");
`endif

endmodule
